@@ hw/rtl/tilt_pkg.sv @@
// Shared types, widths and constants for the accelerometer tilt averager.
package tilt_pkg;

  localparam int IN_W         = 16;
  localparam int VEC_W        = 36;
  localparam int ANG_W        = 28;
  localparam int DEG_W        = 9;
  localparam int PITCH_W      = 9;
  localparam int ROLL_W       = 8;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  localparam int ROOT_W       = 32;
  localparam int ROOT_CNT_W   = 5;
  localparam int REM_W        = 34;
  localparam int FRAC_SH      = 16;

  localparam int AVERAGE_COUNT_DEF = 5;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 28'sd26353589;

  // degrees = trunc(|A| * 573 / (5 * 2^25)); /5 done as *205 >> 10
  localparam logic [9:0] DEG_MUL    = 10'd573;
  localparam int         DEG_PROD_W = ANG_W + 10;
  localparam int         DEG_SH     = 25;
  localparam int         DEG_T_W    = 12;
  localparam logic [7:0] DIV5_MUL   = 8'd205;
  localparam int         DIV5_SH    = 10;

  localparam logic [23:0] ATAN_Q24 [CORDIC_STEPS] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
    24'd1047214,  24'd524117,  24'd262123,  24'd131069,
    24'd65536,    24'd32768,   24'd16384,   24'd8192,
    24'd4096,     24'd2048,    24'd1024,    24'd512,
    24'd256,      24'd128,     24'd64,      24'd32,
    24'd16,       24'd8,       24'd4,       24'd2
  };

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [DEG_W-1:0] deg_t;

  typedef struct packed {
    logic signed [IN_W-1:0] accel_x;
    logic signed [IN_W-1:0] accel_y;
    logic signed [IN_W-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch_average;
    logic signed [ROLL_W-1:0]  roll_average;
  } result_t;

  typedef struct packed {
    logic start;
    vec_t yv;
    vec_t xv;
  } cordic_cmd_t;

  typedef struct packed {
    logic                   start;
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] z;
  } sqrt_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ hw/rtl/tilt_isqrt.sv @@
// Magnitude unit: floor(sqrt((x*x + z*z) * 2^32)), one root digit per cycle.
module tilt_isqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  tilt_pkg::sqrt_cmd_t    cmd,
  output tilt_pkg::unit_stat_t   stat,
  output tilt_pkg::vec_t         mag
);
  import tilt_pkg::*;

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_SQX  = 4'b0010,
    P_SQZ  = 4'b0100,
    P_ROOT = 4'b1000
  } phase_t;

  phase_t                  phase;
  logic signed [IN_W-1:0]  x;
  logic signed [IN_W-1:0]  z;
  logic [2*IN_W-1:0]       sq;
  logic [REM_W-1:0]        rem;
  logic [ROOT_W-1:0]       root;
  logic [ROOT_CNT_W-1:0]   cnt;
  logic                    done;

  logic signed [IN_W-1:0]   mul_in;
  logic signed [2*IN_W-1:0] sq_prod;
  logic [REM_W+1:0]         trial_a;
  logic [REM_W+1:0]         trial_c;

  assign mul_in  = (phase == P_SQX) ? x : z;
  assign sq_prod = mul_in * mul_in;
  assign trial_a = {rem, sq[2*IN_W-1 -: 2]};
  assign trial_c = (REM_W+2)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      case (phase)
        P_IDLE: begin
          if (cmd.start) begin
            x     <= cmd.x;
            z     <= cmd.z;
            done  <= 1'b0;
            phase <= P_SQX;
          end
        end
        P_SQX: begin
          sq    <= sq_prod;
          phase <= P_SQZ;
        end
        P_SQZ: begin
          sq    <= sq + sq_prod;
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          phase <= P_ROOT;
        end
        P_ROOT: begin
          if (trial_a >= trial_c) begin
            rem  <= REM_W'(trial_a - trial_c);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= trial_a[REM_W-1:0];
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          sq  <= {sq[2*IN_W-3:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == ROOT_CNT_W'(ROOT_W - 1)) begin
            done  <= 1'b1;
            phase <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign stat.busy = (phase != P_IDLE);
  assign stat.done = done;
  assign mag       = vec_t'(root);

endmodule

@@ hw/rtl/tilt_cordic.sv @@
// Vectoring CORDIC: one shift-add rotation per cycle, angle in Q24 radians.
module tilt_cordic (
  input  logic                  clk,
  input  logic                  rst,
  input  tilt_pkg::cordic_cmd_t cmd,
  output tilt_pkg::unit_stat_t  stat,
  output tilt_pkg::ang_t        angle
);
  import tilt_pkg::*;

  vec_t              xv;
  vec_t              yv;
  ang_t              ang;
  logic              zero;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;

  vec_t lx;
  vec_t ly;
  ang_t la;
  vec_t dx;
  vec_t dy;
  ang_t at;

  // fold the left half-plane into the right one
  always_comb begin
    lx = cmd.xv;
    ly = cmd.yv;
    la = '0;
    if (cmd.xv[VEC_W-1]) begin
      if (!cmd.yv[VEC_W-1] && (cmd.yv != '0)) begin
        lx = cmd.yv;
        ly = -cmd.xv;
        la = HALF_PI_Q24;
      end else begin
        lx = -cmd.yv;
        ly = cmd.xv;
        la = -HALF_PI_Q24;
      end
    end
  end

  assign dx = yv >>> step;
  assign dy = xv >>> step;
  assign at = ang_t'(ATAN_Q24[step]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (cmd.start) begin
      xv   <= lx;
      yv   <= ly;
      ang  <= la;
      zero <= (cmd.xv == '0) && (cmd.yv == '0);
      step <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (!yv[VEC_W-1]) begin
        xv  <= xv + dx;
        yv  <= yv - dy;
        ang <= ang + at;
      end else begin
        xv  <= xv - dx;
        yv  <= yv + dy;
        ang <= ang - at;
      end
      step <= step + 1'b1;
      if (step == STEP_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign angle     = zero ? ang_t'(0) : ang;

endmodule

@@ hw/rtl/tilt_avg.sv @@
// Running sums, window count, divide by the window length and output word register.
module tilt_avg #(
  parameter int AVERAGE_COUNT = tilt_pkg::AVERAGE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              add,
  input  tilt_pkg::deg_t    pitch_deg,
  input  tilt_pkg::deg_t    roll_deg,
  output logic              busy,
  output logic              result_valid,
  input  logic              result_stall,
  output tilt_pkg::result_t result
);
  import tilt_pkg::*;

  localparam int CNT_W    = $clog2(AVERAGE_COUNT + 1);
  localparam int SUM_W    = DEG_W + $clog2(AVERAGE_COUNT + 1);
  localparam int DIV_SH   = 24;
  localparam int RECIP_W  = DIV_SH + 1;
  localparam int RECIP_I  = ((1 << DIV_SH) + AVERAGE_COUNT - 1) / AVERAGE_COUNT;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_I);
  localparam int PROD_W   = SUM_W + RECIP_W;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_DIVP = 4'b0010,
    A_DIVR = 4'b0100,
    A_EMIT = 4'b1000
  } avg_state_t;

  avg_state_t              state;
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] pitch_sum;
  logic signed [SUM_W-1:0] roll_sum;
  logic [PROD_W-1:0]       prod;
  logic                    pitch_neg;
  logic                    roll_neg;
  logic [DEG_W-1:0]        pitch_q;

  logic [SUM_W-1:0]  mul_in;
  logic [DEG_W-1:0]  roll_q;
  logic [DEG_W-1:0]  pitch_s;
  logic [DEG_W-1:0]  roll_s;
  logic              slot_free;

  always_comb begin
    if (state == A_DIVP) begin
      mul_in = pitch_sum[SUM_W-1] ? SUM_W'(-pitch_sum) : SUM_W'(pitch_sum);
    end else begin
      mul_in = roll_sum[SUM_W-1] ? SUM_W'(-roll_sum) : SUM_W'(roll_sum);
    end
  end

  assign roll_q    = prod[DIV_SH +: DEG_W];
  assign pitch_s   = pitch_neg ? DEG_W'(~pitch_q + 1'b1) : pitch_q;
  assign roll_s    = roll_neg ? DEG_W'(~roll_q + 1'b1) : roll_q;
  assign slot_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= A_IDLE;
      count        <= '0;
      pitch_sum    <= '0;
      roll_sum     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != A_EMIT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        A_IDLE: begin
          if (add) begin
            pitch_sum <= pitch_sum + SUM_W'(pitch_deg);
            roll_sum  <= roll_sum + SUM_W'(roll_deg);
            if (count == CNT_W'(AVERAGE_COUNT - 1)) begin
              count <= '0;
              state <= A_DIVP;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        A_DIVP: begin
          prod      <= PROD_W'(mul_in) * PROD_W'(RECIP);
          pitch_neg <= pitch_sum[SUM_W-1];
          state     <= A_DIVR;
        end
        A_DIVR: begin
          pitch_q  <= prod[DIV_SH +: DEG_W];
          prod     <= PROD_W'(mul_in) * PROD_W'(RECIP);
          roll_neg <= roll_sum[SUM_W-1];
          state    <= A_EMIT;
        end
        A_EMIT: begin
          if (slot_free) begin
            result.pitch_average <= pitch_s[PITCH_W-1:0];
            result.roll_average  <= roll_s[ROLL_W-1:0];
            result_valid         <= 1'b1;
            pitch_sum            <= '0;
            roll_sum             <= '0;
            state                <= A_IDLE;
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign busy = (state != A_IDLE);

endmodule

@@ hw/rtl/accel_tilt_angle_averager_top.sv @@
// Tilt averager top: sequencer, degree conversion and unit wiring.
// Each accepted sample word yields pitch = atan2(-x, z) and roll = atan2(y, |(x, z)|)
// in whole degrees (truncated toward zero); every AVERAGE_COUNT samples one result word
// carries both sums divided by AVERAGE_COUNT, truncated toward zero. Between acceptance of
// a sample and the next possible acceptance lie the square root unit (squaring of x and z
// and 32 root digits, overlapped with the pitch rotations) followed by the 24 roll rotations
// of the shared CORDIC unit, the degree conversion and the hand-off to the averager, and,
// when the sample closes a window, the averager's division. The sample side stalls
// throughout; a finished result word waits in its own register and does not hold up the
// next sample unless the following window closes while it is still waiting.
module accel_tilt_angle_averager_top #(
  parameter int AVERAGE_COUNT = tilt_pkg::AVERAGE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  tilt_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output tilt_pkg::result_t result
);
  import tilt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CORDIC = 7'b0000010,
    S_DEG1   = 7'b0000100,
    S_DEG2   = 7'b0001000,
    S_WAIT   = 7'b0010000,
    S_ACC    = 7'b0100000,
    S_DRAIN  = 7'b1000000
  } state_t;

  state_t                  state;
  logic                    roll_phase;
  logic signed [IN_W-1:0]  accel_y;
  logic [DEG_PROD_W-1:0]   deg_prod;
  logic                    deg_neg;
  deg_t                    pitch_deg;
  deg_t                    roll_deg;

  logic         accept;
  cordic_cmd_t  cordic_cmd;
  unit_stat_t   cordic_stat;
  ang_t         cordic_angle;
  sqrt_cmd_t    sqrt_cmd;
  unit_stat_t   sqrt_stat;
  vec_t         mag;
  logic         avg_busy;

  logic [ANG_W-1:0]            ang_mag;
  logic [DEG_T_W-1:0]          deg_t5;
  logic [DEG_T_W+7:0]          deg_q_full;
  logic [DEG_W-1:0]            deg_q;
  deg_t                        deg_val;

  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;

  always_comb begin
    cordic_cmd.start = accept || ((state == S_WAIT) && sqrt_stat.done);
    if (state == S_IDLE) begin
      cordic_cmd.yv = -(vec_t'(sample.accel_x) <<< FRAC_SH);
      cordic_cmd.xv = vec_t'(sample.accel_z) <<< FRAC_SH;
    end else begin
      cordic_cmd.yv = vec_t'(accel_y) <<< FRAC_SH;
      cordic_cmd.xv = mag;
    end
  end

  assign sqrt_cmd.start = accept;
  assign sqrt_cmd.x     = sample.accel_x;
  assign sqrt_cmd.z     = sample.accel_z;

  tilt_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cordic_cmd),
    .stat  (cordic_stat),
    .angle (cordic_angle)
  );

  tilt_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .cmd  (sqrt_cmd),
    .stat (sqrt_stat),
    .mag  (mag)
  );

  tilt_avg #(
    .AVERAGE_COUNT (AVERAGE_COUNT)
  ) u_avg (
    .clk          (clk),
    .rst          (rst),
    .add          (state == S_ACC),
    .pitch_deg    (pitch_deg),
    .roll_deg     (roll_deg),
    .busy         (avg_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Q24 radians to whole degrees
  assign ang_mag    = cordic_angle[ANG_W-1] ? ANG_W'(-cordic_angle) : ANG_W'(cordic_angle);
  assign deg_t5     = deg_prod[DEG_SH +: DEG_T_W];
  assign deg_q_full = (DEG_T_W+8)'(deg_t5) * (DEG_T_W+8)'(DIV5_MUL);
  assign deg_q      = deg_q_full[DIV5_SH +: DEG_W];
  assign deg_val    = deg_neg ? deg_t'(~deg_q + 1'b1) : deg_t'(deg_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      roll_phase <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            accel_y    <= sample.accel_y;
            roll_phase <= 1'b0;
            state      <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cordic_stat.done) begin
            state <= S_DEG1;
          end
        end
        S_DEG1: begin
          deg_prod <= DEG_PROD_W'(ang_mag) * DEG_PROD_W'(DEG_MUL);
          deg_neg  <= cordic_angle[ANG_W-1];
          state    <= S_DEG2;
        end
        S_DEG2: begin
          if (roll_phase) begin
            roll_deg <= deg_val;
            state    <= S_ACC;
          end else begin
            pitch_deg <= deg_val;
            state     <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (sqrt_stat.done) begin
            roll_phase <= 1'b1;
            state      <= S_CORDIC;
          end
        end
        S_ACC: begin
          state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!avg_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> sample_stall)
    else $error("sample side not stalled after a word was taken");

  a_result_in_window: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> sample_stall)
    else $error("result word appeared outside sample processing");

  a_roll_start: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WAIT) && sqrt_stat.done) |=> cordic_stat.busy)
    else $error("roll rotation did not start once magnitude was ready");

endmodule

@@ sim/tilt_average_checker.sv @@
// Checker for the tilt averager: predicts window averages from accepted samples and compares.
`timescale 1ns / 100ps

module tilt_average_checker #(
  parameter int AVERAGE_COUNT = tilt_pkg::AVERAGE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  input  logic              sample_stall,
  input  tilt_pkg::sample_t sample,
  input  logic              result_valid,
  input  logic              result_stall,
  input  tilt_pkg::result_t result,
  output int                results_due,
  output int                fail_count
);

  localparam longint HALF_PI_RAD = 64'sd26353589;
  localparam longint DEG_DIV     = 64'sd167772160;

  localparam longint ARCTAN_STEP [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  tilt_pkg::result_t avg_due_q[$];
  int                window_n;
  int                pitch_acc;
  int                roll_acc;

  // vectoring rotation, angle in radians with 24 fractional bits
  function automatic longint vector_angle(input longint yv_in, input longint xv_in);
    longint yv, xv, ang, dx, dy, t;
    int     i;
    yv  = yv_in;
    xv  = xv_in;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv > 0) begin
        xv  = yv;
        yv  = -t;
        ang = HALF_PI_RAD;
      end else begin
        xv  = -yv;
        yv  = t;
        ang = -HALF_PI_RAD;
      end
    end
    for (i = 0; i < 24; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv  += dx;
        yv  -= dy;
        ang += ARCTAN_STEP[i];
      end else begin
        xv  -= dx;
        yv  += dy;
        ang -= ARCTAN_STEP[i];
      end
    end
    return ang;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned n_in);
    longint unsigned n, root, probe;
    n     = n_in;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic int whole_degrees(input longint ang);
    return int'((ang * 573) / DEG_DIV);
  endfunction

  task automatic tilt_angles(input tilt_pkg::sample_t s, output int pitch_deg,
                             output int roll_deg);
    longint          x, y, z;
    longint unsigned sq, mag;
    x         = s.accel_x;
    y         = s.accel_y;
    z         = s.accel_z;
    sq        = longint'(x * x + z * z);
    mag       = floor_root(sq << 32);
    pitch_deg = whole_degrees(vector_angle(-x * 65536, z * 65536));
    roll_deg  = whole_degrees(vector_angle(y * 65536, longint'(mag)));
  endtask

  always @(posedge clk) begin
    tilt_pkg::result_t want;
    int                pitch_deg, roll_deg;
    if (rst) begin
      avg_due_q.delete();
      window_n   = 0;
      pitch_acc  = 0;
      roll_acc   = 0;
      fail_count = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (avg_due_q.size() == 0) begin
          $error("result word with no window average due: pitch %0d roll %0d",
                 result.pitch_average, result.roll_average);
          fail_count++;
        end else begin
          want = avg_due_q.pop_front();
          if (result.pitch_average !== want.pitch_average) begin
            $error("pitch_average: expected %0d, got %0d",
                   want.pitch_average, result.pitch_average);
            fail_count++;
          end
          if (result.roll_average !== want.roll_average) begin
            $error("roll_average: expected %0d, got %0d",
                   want.roll_average, result.roll_average);
            fail_count++;
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        tilt_angles(sample, pitch_deg, roll_deg);
        pitch_acc += pitch_deg;
        roll_acc  += roll_deg;
        window_n++;
        if (window_n == AVERAGE_COUNT) begin
          want.pitch_average = 9'(pitch_acc / AVERAGE_COUNT);
          want.roll_average  = 8'(roll_acc / AVERAGE_COUNT);
          avg_due_q.push_back(want);
          window_n  = 0;
          pitch_acc = 0;
          roll_acc  = 0;
        end
      end
    end
    results_due <= avg_due_q.size();
  end

endmodule

@@ sim/accel_tilt_angle_averager_top_tb.sv @@
// Testbench top for the tilt averager: clock, reset, sample and result traffic, verdict.
`timescale 1ns / 100ps

module accel_tilt_angle_averager_top_tb;

  logic              clk;
  logic              rst;
  logic              sample_valid;
  logic              sample_stall;
  tilt_pkg::sample_t sample;
  logic              result_valid;
  logic              result_stall;
  tilt_pkg::result_t result;
  int                results_due;
  int                fail_count;

  int src_idle_pct;
  int dst_idle_pct;
  int hold_req;

  accel_tilt_angle_averager_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  tilt_average_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .results_due  (results_due),
    .fail_count   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("** accel_tilt_angle_averager_top: FAILED **");
    $finish;
  end

  // result side: random stall, or a long hold-off when asked
  initial begin
    int hold_left;
    hold_left    = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < dst_idle_pct);
      end
    end
  end

  task automatic put_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic signed [15:0] z);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid   <= 1'b1;
    sample.accel_x <= x;
    sample.accel_y <= y;
    sample.accel_z <= z;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(256)) - 128);
      2: begin
        case ($urandom_range(4))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      default: return 16'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic random_samples(input int n);
    logic signed [15:0] x, y, z;
    for (int k = 0; k < n; k++) begin
      x = pick_axis();
      y = pick_axis();
      z = pick_axis();
      case ($urandom_range(15))
        0: begin
          x = '0;
          z = '0;
        end
        1: x = '0;
        default: ;
      endcase
      put_sample(x, y, z);
    end
  endtask

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_req     = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero vector, pitch -180 cases, roll +-90, extremes
    put_sample(16'sd0, 16'sd0, 16'sd0);
    put_sample(16'sd0, 16'sd0, -16'sd100);
    put_sample(16'sd0, 16'sd0, -16'sd32768);
    put_sample(16'sd0, 16'sd500, 16'sd0);
    put_sample(16'sd0, -16'sd500, 16'sd0);
    put_sample(16'sd32767, 16'sd32767, 16'sd32767);
    put_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    put_sample(16'sd32767, -16'sd32768, 16'sd0);
    put_sample(-16'sd32768, 16'sd32767, 16'sd0);
    put_sample(16'sd0, 16'sd0, 16'sd16384);
    put_sample(16'sd16384, 16'sd0, 16'sd0);
    put_sample(-16'sd16384, 16'sd0, 16'sd0);
    put_sample(16'sd0, 16'sd16384, 16'sd16384);
    put_sample(16'sd100, -16'sd100, -16'sd16000);
    put_sample(-16'sd1, 16'sd1, -16'sd1);
    put_sample(16'sd1, -16'sd1, 16'sd1);
    put_sample(16'sd0, 16'sd32767, 16'sd0);
    put_sample(16'sd0, -16'sd32768, -16'sd1);
    put_sample(-16'sd32768, 16'sd0, 16'sd32767);
    put_sample(16'sd32767, 16'sd0, -16'sd32768);

    src_idle_pct = 7;
    dst_idle_pct = 87;
    random_samples(600);

    src_idle_pct = 87;
    dst_idle_pct = 7;
    random_samples(600);

    // long hold-off on the result side while samples keep coming
    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_req     = 2000;
    random_samples(600);

    sample_valid <= 1'b0;
    while (results_due != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("** accel_tilt_angle_averager_top: PASSED **");
    end else begin
      $display("** accel_tilt_angle_averager_top: FAILED **");
    end
    $finish;
  end

endmodule
